// ----- rtl/core/fk_to_fv_spectrum_resampler_defines.svh -----
// Assertion macros shared by the resampler RTL.
// Define ASSERT_OFF to compile the checks out; needs clk_i and rst_ni in scope.
`ifndef FK_TO_FV_SPECTRUM_RESAMPLER_DEFINES_SVH
`define FK_TO_FV_SPECTRUM_RESAMPLER_DEFINES_SVH
`ifndef ASSERT_OFF
`define FKFV_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("fkfv check failed");
`define FKFV_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) (prop)) \
    else $error("fkfv check failed");
`else
`define FKFV_ASSERT(name, prop)
`define FKFV_ASSERT_ALWAYS(name, prop)
`endif
`endif

// ----- rtl/core/fkfv_pkg.sv -----
// Shared types, field widths and register codes of the fk-to-fv resampler.
// No dependencies; imported by the interfaces, the divider, the resampler and the testbench.
`timescale 1ns / 1ps
package fkfv_pkg;

  localparam int K_DEPTH_DEF     = 256;
  localparam int F_DEPTH_DEF     = 256;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam int KIDX_W  = 8;
  localparam int FIDX_W  = 8;
  localparam int VIDX_W  = 11;
  localparam int KCNT_W  = 9;
  localparam int KCTR_W  = 25;
  localparam int SLOPE_W = 32;
  localparam int VHALF_W = 10;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int FRAC_W = 16;
  localparam int RF_W   = SLOPE_W + FIDX_W;  // slope_ratio * f
  localparam int AJ_W   = VIDX_W;            // |v - velocity_half|
  localparam int AJK_W  = AJ_W + KCTR_W;     // |j| * k_center
  localparam int QUO_W  = KCTR_W;            // quotient inside the cone never exceeds k_center
  localparam int WGT_W  = FRAC_W + 1;        // Q1.16 weight incl. 1.0

  localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(1) << FRAC_W;
  localparam int ROUND_HALF = 1 << (FRAC_W - 1);

  localparam logic [KCNT_W-1:0]  K_COUNT_RST       = KCNT_W'(256);
  localparam logic [KCTR_W-1:0]  K_CENTER_RST      = KCTR_W'(8388608);
  localparam logic [SLOPE_W-1:0] SLOPE_RATIO_RST   = SLOPE_W'(65536);
  localparam logic [VHALF_W-1:0] VELOCITY_HALF_RST = VHALF_W'(100);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_K_COUNT       = 2'd0,
    CFG_K_CENTER      = 2'd1,
    CFG_SLOPE_RATIO   = 2'd2,
    CFG_VELOCITY_HALF = 2'd3
  } cfg_idx_e;

endpackage

// ----- rtl/core/fkfv_intf.sv -----
// Valid/ready channel interfaces: input item, result and configuration write.
// Depends on fkfv_pkg.
`timescale 1ns / 1ps
interface fkfv_item_if import fkfv_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                    valid;
  logic                    ready;
  opcode_e                 opcode;
  logic [KIDX_W-1:0]       k_index;
  logic [FIDX_W-1:0]       f_index;
  logic [VIDX_W-1:0]       v_index;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, opcode, k_index, f_index, v_index, sample, input ready);
  modport sink   (input valid, opcode, k_index, f_index, v_index, sample, output ready);
endinterface

interface fkfv_result_if import fkfv_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] value;

  modport source (output valid, value, input ready);
  modport sink   (input valid, value, output ready);
endinterface

interface fkfv_cfg_if import fkfv_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/fkfv_ram.sv -----
// Generic single-port RAM with registered read and clock enable.
// No dependencies.
`timescale 1ns / 1ps
module fkfv_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/fkfv_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
// Depends on fkfv_pkg for default widths.
`timescale 1ns / 1ps
module fkfv_div import fkfv_pkg::*; #(
  parameter int NW = RF_W,
  parameter int DW = AJ_W,
  parameter int QW = QUO_W,
  parameter int TW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [TW-1:0] tag_i,
  output logic          valid_o,
  output logic [QW-1:0] quot_o,
  output logic [TW-1:0] tag_o
);

  logic          vld_q  [QW];
  logic [NW-1:0] rem_q  [QW];
  logic [DW-1:0] den_q  [QW];
  logic [QW-1:0] quot_q [QW];
  logic [TW-1:0] tag_q  [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int Bit = QW - 1 - s;
    logic          vld_in;
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quot_in;
    logic [TW-1:0] tag_in;
    logic [NW-1:0] dsh;
    logic          take;

    if (s == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = num_i;
      assign den_in  = den_i;
      assign quot_in = '0;
      assign tag_in  = tag_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign den_in  = den_q[s-1];
      assign quot_in = quot_q[s-1];
      assign tag_in  = tag_q[s-1];
    end

    assign dsh  = NW'(den_in) << Bit;
    assign take = (rem_in >= dsh);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= take ? (rem_in - dsh) : rem_in;
        den_q[s]  <= den_in;
        quot_q[s] <= quot_in | (QW'(take) << Bit);
        tag_q[s]  <= tag_in;
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quot_o  = quot_q[QW-1];
  assign tag_o   = tag_q[QW-1];

endmodule

// ----- rtl/core/fk_to_fv_spectrum_resampler.sv -----
// fk_to_fv_spectrum_resampler: stores an f-k spectrum, answers f-v point queries.
// Pipeline: 3 front stages, 25-stage divider, 3 index stages, memory read,
//   product, round/saturate. Every stage, divider included, takes one per cycle.
// Throughput: one transaction per cycle while the result register is not blocked.
// Reset: valid bits and config registers clear to defaults; memory is not cleared.
// Depends on fkfv_pkg, fkfv_intf, fkfv_div, fkfv_ram and the defines header.
`timescale 1ns / 1ps
`include "fk_to_fv_spectrum_resampler_defines.svh"
module fk_to_fv_spectrum_resampler import fkfv_pkg::*; #(
  parameter int K_DEPTH     = K_DEPTH_DEF,
  parameter int F_DEPTH     = F_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  fkfv_item_if.sink       item_i,
  fkfv_result_if.source   result_o,
  fkfv_cfg_if.sink        cfg_i
);

  // Row index width, clamped-count width, clamped position width, store address.
  localparam int RW     = (K_DEPTH > 2) ? $clog2(K_DEPTH) : 1;
  localparam int CW     = ($clog2(K_DEPTH + 1) > KCNT_W) ? $clog2(K_DEPTH + 1) : KCNT_W;
  localparam int PW     = (RW + FRAC_W > KCTR_W + 1) ? RW + FRAC_W : KCTR_W + 1;
  localparam int DEPTH  = K_DEPTH * F_DEPTH;
  localparam int AW     = $clog2(DEPTH);
  localparam int PROD_W = WGT_W + 1 + SAMPLE_BITS;
  localparam int ACC_W  = PROD_W + 1;
  localparam longint SmaxL = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
  localparam logic signed [ACC_W-1:0] SMAX = ACC_W'(SmaxL);
  localparam logic signed [ACC_W-1:0] SMIN = ACC_W'(-SmaxL - 64'sd1);

  // Item context that rides along the front half and through the divider.
  typedef struct packed {
    opcode_e                 op;
    logic [KIDX_W-1:0]       k;
    logic [FIDX_W-1:0]       f;
    logic [SAMPLE_BITS-1:0]  sample;
    logic                    zero;   // result forced to 0
    logic                    neg;    // negative velocity offset: mirror rows
  } tag_t;

  // ---------------------------------------------------------------------------
  // Configuration registers. User writes only while the pipeline is drained; not enforced.
  // ---------------------------------------------------------------------------
  logic [KCNT_W-1:0]  k_count_q;
  logic [KCTR_W-1:0]  k_center_q;
  logic [SLOPE_W-1:0] slope_ratio_q;
  logic [VHALF_W-1:0] velocity_half_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_count_q       <= K_COUNT_RST;
      k_center_q      <= K_CENTER_RST;
      slope_ratio_q   <= SLOPE_RATIO_RST;
      velocity_half_q <= VELOCITY_HALF_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_K_COUNT:       k_count_q       <= cfg_i.data[KCNT_W-1:0];
        CFG_K_CENTER:      k_center_q      <= cfg_i.data[KCTR_W-1:0];
        CFG_SLOPE_RATIO:   slope_ratio_q   <= cfg_i.data[SLOPE_W-1:0];
        CFG_VELOCITY_HALF: velocity_half_q <= cfg_i.data[VHALF_W-1:0];
        default: ;
      endcase
    end
  end

  // Row count clamped to [2, K_DEPTH]; static in flight only if written while drained.
  logic [CW-1:0] cnt_ext, cnt;
  logic [RW-1:0] cnt_m1;
  logic [PW-1:0] lim;

  always_comb begin
    cnt_ext = CW'(k_count_q);
    if (cnt_ext < CW'(2)) begin
      cnt = CW'(2);
    end else if (cnt_ext > CW'(K_DEPTH)) begin
      cnt = CW'(K_DEPTH);
    end else begin
      cnt = cnt_ext;
    end
    cnt_m1 = RW'(cnt - CW'(1));
    lim    = PW'({cnt_m1, {FRAC_W{1'b0}}});
  end

  // ---------------------------------------------------------------------------
  // Global advance: every stage moves unless the result register is blocked.
  // ---------------------------------------------------------------------------
  logic adv;
  logic out_vld_q;
  logic signed [SAMPLE_BITS-1:0] out_value_q;

  assign adv          = !out_vld_q || result_o.ready;
  assign item_i.ready = adv;

  // Stage 1: input register.
  logic                   s1_vld_q;
  opcode_e                s1_op_q;
  logic [KIDX_W-1:0]      s1_k_q;
  logic [FIDX_W-1:0]      s1_f_q;
  logic [VIDX_W-1:0]      s1_v_q;
  logic [SAMPLE_BITS-1:0] s1_smp_q;

  // Stage 2: velocity offset j, |j|, early zero checks.
  logic signed [VIDX_W:0] j_s1;
  logic                   j_neg;
  logic [AJ_W-1:0]        aj_s1;
  tag_t                   tag_s1;

  always_comb begin
    j_s1   = $signed({1'b0, s1_v_q}) - $signed({2'b00, velocity_half_q});
    j_neg  = j_s1[VIDX_W];
    aj_s1  = j_neg ? AJ_W'(-j_s1) : AJ_W'(j_s1);
    tag_s1 = '{op: s1_op_q, k: s1_k_q, f: s1_f_q, sample: s1_smp_q,
               zero: (s1_f_q == '0) || (j_s1 == '0) || !(int'(s1_f_q) < F_DEPTH),
               neg: j_neg};
  end

  logic            s2_vld_q;
  tag_t            s2_tag_q;
  logic [AJ_W-1:0] s2_aj_q;

  // Stage 3: the two products that feed the range check and the divider.
  logic             s3_vld_q;
  tag_t             s3_tag_q;
  logic [AJ_W-1:0]  s3_aj_q;
  logic [RF_W-1:0]  s3_rf_q;
  logic [AJK_W-1:0] s3_ajk_q;

  // Below the cone |j|*center < ratio*f the point has no spectrum value.
  tag_t div_tag_in;
  always_comb begin
    div_tag_in      = s3_tag_q;
    div_tag_in.zero = s3_tag_q.zero || (RF_W'(s3_ajk_q) < s3_rf_q);
  end

  logic              div_vld;
  logic [QUO_W-1:0]  div_quot;
  tag_t              div_tag;

  fkfv_div #(
    .NW (RF_W),
    .DW (AJ_W),
    .QW (QUO_W),
    .TW ($bits(tag_t))
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s3_vld_q),
    .num_i   (s3_rf_q),
    .den_i   (s3_aj_q),
    .tag_i   (div_tag_in),
    .valid_o (div_vld),
    .quot_o  (div_quot),
    .tag_o   (div_tag)
  );

  // Stage 4: position p = ratio*f/|j| + center, clamped to the last row.
  logic          s4_vld_q;
  tag_t          s4_tag_q;
  logic [PW-1:0] s4_pc_q;
  logic [PW-1:0] p_sum;

  assign p_sum = PW'(div_quot) + PW'(k_center_q);

  // Stage 5: upper/lower rows and their Q1.16 weights.
  // An integral position gives full weight to its own row, except position
  // zero, which keeps rows 1/0 with all weight on row 0.
  logic [PW-FRAC_W-1:0] whole;
  logic [FRAC_W-1:0]    frac;
  logic [RW-1:0]        up_s4;
  logic [WGT_W-1:0]     wu_s4;

  always_comb begin
    whole = s4_pc_q[PW-1:FRAC_W];
    frac  = s4_pc_q[FRAC_W-1:0];
    if (frac != '0) begin
      up_s4 = RW'(whole + (PW-FRAC_W)'(1));
      wu_s4 = WGT_W'(frac);
    end else if (whole == '0) begin
      up_s4 = RW'(1);
      wu_s4 = '0;
    end else begin
      up_s4 = RW'(whole);
      wu_s4 = WGT_ONE;
    end
  end

  logic             s5_vld_q;
  tag_t             s5_tag_q;
  logic [RW-1:0]    s5_up_q, s5_lo_q;
  logic [WGT_W-1:0] s5_wu_q, s5_wl_q;

  // Stage 6: mirrored rows and store addresses; writes take their own address.
  logic [RW-1:0] ru, rl;
  logic [AW-1:0] addr_u, addr_l, addr_w;
  logic          we_s5;

  always_comb begin
    ru     = s5_tag_q.neg ? (cnt_m1 - s5_up_q) : s5_up_q;
    rl     = s5_tag_q.neg ? (cnt_m1 - s5_lo_q) : s5_lo_q;
    addr_w = AW'(s5_tag_q.k) * AW'(F_DEPTH) + AW'(s5_tag_q.f);
    addr_u = AW'(ru) * AW'(F_DEPTH) + AW'(s5_tag_q.f);
    addr_l = AW'(rl) * AW'(F_DEPTH) + AW'(s5_tag_q.f);
    we_s5  = s5_vld_q && (s5_tag_q.op == OP_WRITE) &&
             (int'(s5_tag_q.k) < K_DEPTH) && (int'(s5_tag_q.f) < F_DEPTH);
  end

  logic                   s6_vld_q, s6_we_q;
  logic                   s6_zero_q;
  logic [AW-1:0]          s6_addr_u_q, s6_addr_l_q;
  logic [SAMPLE_BITS-1:0] s6_wdata_q;
  logic [WGT_W-1:0]       s6_wu_q, s6_wl_q;

  // Stage 7: two copies of the store give both rows in the same read; every
  // write lands in both. Writes reach the store in item order with reads.
  logic [SAMPLE_BITS-1:0] rd_u, rd_l;

  fkfv_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DEPTH)) u_ram_up (
    .clk_i   (clk_i),
    .en_i    (adv),
    .we_i    (s6_we_q),
    .addr_i  (s6_addr_u_q),
    .wdata_i (s6_wdata_q),
    .rdata_o (rd_u)
  );

  fkfv_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DEPTH)) u_ram_lo (
    .clk_i   (clk_i),
    .en_i    (adv),
    .we_i    (s6_we_q),
    .addr_i  (s6_addr_l_q),
    .wdata_i (s6_wdata_q),
    .rdata_o (rd_l)
  );

  logic             s7_vld_q, s7_zero_q;
  logic [WGT_W-1:0] s7_wu_q, s7_wl_q;

  // Stage 8: weighted samples.
  logic                     s8_vld_q, s8_zero_q;
  logic signed [PROD_W-1:0] s8_pu_q, s8_pl_q;

  // Output: round half up, floor shift, saturate.
  logic signed [ACC_W-1:0] acc, shr, sat;

  always_comb begin
    acc = ACC_W'(s8_pu_q) + ACC_W'(s8_pl_q) + ACC_W'(ROUND_HALF);
    shr = acc >>> FRAC_W;
    if (shr > SMAX) begin
      sat = SMAX;
    end else if (shr < SMIN) begin
      sat = SMIN;
    end else begin
      sat = shr;
    end
  end

  // ---------------------------------------------------------------------------
  // Valid bits.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      s6_vld_q  <= 1'b0;
      s6_we_q   <= 1'b0;
      s7_vld_q  <= 1'b0;
      s8_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= item_i.valid;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= div_vld;
      s5_vld_q  <= s4_vld_q;
      // Writes retire in the store; only queries go on.
      s6_vld_q  <= s5_vld_q && (s5_tag_q.op == OP_QUERY);
      s6_we_q   <= we_s5;
      s7_vld_q  <= s6_vld_q;
      s8_vld_q  <= s7_vld_q;
      out_vld_q <= s8_vld_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_op_q     <= item_i.opcode;
      s1_k_q      <= item_i.k_index;
      s1_f_q      <= item_i.f_index;
      s1_v_q      <= item_i.v_index;
      s1_smp_q    <= item_i.sample;

      s2_tag_q    <= tag_s1;
      s2_aj_q     <= aj_s1;

      s3_tag_q    <= s2_tag_q;
      s3_aj_q     <= s2_aj_q;
      s3_rf_q     <= RF_W'(slope_ratio_q) * RF_W'(s2_tag_q.f);
      s3_ajk_q    <= AJK_W'(s2_aj_q) * AJK_W'(k_center_q);

      s4_tag_q    <= div_tag;
      s4_pc_q     <= (p_sum > lim) ? lim : p_sum;

      s5_tag_q    <= s4_tag_q;
      s5_up_q     <= up_s4;
      s5_lo_q     <= up_s4 - RW'(1);
      s5_wu_q     <= wu_s4;
      s5_wl_q     <= WGT_ONE - wu_s4;

      s6_zero_q   <= s5_tag_q.zero;
      s6_addr_u_q <= (s5_tag_q.op == OP_WRITE) ? addr_w : addr_u;
      s6_addr_l_q <= (s5_tag_q.op == OP_WRITE) ? addr_w : addr_l;
      s6_wdata_q  <= s5_tag_q.sample;
      s6_wu_q     <= s5_wu_q;
      s6_wl_q     <= s5_wl_q;

      s7_zero_q   <= s6_zero_q;
      s7_wu_q     <= s6_wu_q;
      s7_wl_q     <= s6_wl_q;

      s8_zero_q   <= s7_zero_q;
      s8_pu_q     <= $signed({1'b0, s7_wu_q}) * $signed(rd_u);
      s8_pl_q     <= $signed({1'b0, s7_wl_q}) * $signed(rd_l);

      out_value_q <= s8_zero_q ? '0 : sat[SAMPLE_BITS-1:0];
    end
  end

  assign result_o.valid = out_vld_q;
  assign result_o.value = out_value_q;

  // ---------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------
  // Inside the cone the quotient cannot pass k_center.
  `FKFV_ASSERT(a_quot_bound, (div_vld && div_tag.op == OP_QUERY && !div_tag.zero) |-> (PW'(div_quot) <= PW'(k_center_q)))
  // Clamped position never passes the last row.
  `FKFV_ASSERT(a_pos_clamp, s4_vld_q |-> (s4_pc_q <= lim))
  // Both rows, mirrored or not, stay inside the valid row range.
  `FKFV_ASSERT(a_row_range, s5_vld_q |-> (ru <= cnt_m1 && rl <= cnt_m1 && s5_lo_q + RW'(1) == s5_up_q))

endmodule

// ----- dv/tb_fk_to_fv_spectrum_resampler.sv -----
// Self-checking testbench for fk_to_fv_spectrum_resampler: predicts each query's
// interpolated value and checks every result transaction in order.
// Depends on fkfv_pkg, fkfv_intf and the resampler RTL.
`timescale 1ns / 1ps
module tb_fk_to_fv_spectrum_resampler;
  import fkfv_pkg::*;

  localparam int  LATENCY_WAIT = 40;       // flush wait, longer than the block latency
  localparam int  CYCLE_LIMIT  = 600000;
  localparam int  LONG_HOLD    = 300;      // receiver hold-off, fills the pipeline
  localparam int  PHASE_ITEMS  = 225;      // transactions per register setting
  localparam longint SMAX = (longint'(1) << (SAMPLE_BITS_DEF - 1)) - 1;
  localparam longint SMIN = -SMAX - 1;

  typedef struct {
    opcode_e                  op;
    logic [KIDX_W-1:0]        k;
    logic [FIDX_W-1:0]        f;
    logic [VIDX_W-1:0]        v;
    logic signed [23:0]       s;
    bit                       has_exp;
    logic signed [23:0]       exp_val;
  } stim_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  fkfv_item_if   item_if ();
  fkfv_result_if res_if ();
  fkfv_cfg_if    cfg_if ();

  fk_to_fv_spectrum_resampler u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  // Shadow copy of the spectrum and the register file
  int                spec_mem [256][256];
  bit                spec_written [256][256];
  logic [KCNT_W-1:0]  k_cnt;
  logic [KCTR_W-1:0]  k_ctr;
  logic [SLOPE_W-1:0] slope;
  logic [VHALF_W-1:0] v_half;

  logic signed [23:0] value_q [$];   // interpolated values still due from the block
  int  errors = 0;
  int  n_writes = 0, n_queries = 0, n_nonzero = 0, n_phases = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;      // no idling on either side
  bit  hold_req = 1'b0;   // ask the receiver for one long hold-off
  int  stall_left = 0;

  // Finds the two rows a query interpolates between; returns 0 when the
  // answer is zero without a memory read (f = 0, zero velocity, outside cone).
  function automatic bit locate_rows(input logic [7:0] f, input logic [10:0] v,
                                     output int row_up, output int row_lo,
                                     output longint w_up);
    longint j, aj, rf, cnt, p, lim, up, lo;
    row_up = 0;
    row_lo = 0;
    w_up   = 0;
    j = longint'(v) - longint'(v_half);
    if (f == 0 || j == 0) return 1'b0;
    aj = (j < 0) ? -j : j;
    rf = longint'(slope) * longint'(f);
    if (aj * longint'(k_ctr) < rf) return 1'b0;
    cnt = longint'(k_cnt);
    if (cnt < 2) cnt = 2;
    if (cnt > 256) cnt = 256;
    p   = rf / aj + longint'(k_ctr);
    lim = (cnt - 1) << 16;
    if (p > lim) p = lim;
    up = (p + 65535) >> 16;
    if (up < 1) up = 1;
    lo   = up - 1;
    w_up = p - (lo << 16);
    if (j < 0) begin
      row_up = int'(cnt - 1 - up);
      row_lo = int'(cnt - 1 - lo);
    end else begin
      row_up = int'(up);
      row_lo = int'(lo);
    end
    return 1'b1;
  endfunction

  function automatic logic signed [23:0] interp_value(input logic [7:0] f,
                                                      input logic [10:0] v);
    int ru, rl;
    longint wu, acc, res;
    if (!locate_rows(f, v, ru, rl, wu)) return '0;
    acc = wu * longint'(spec_mem[ru][f]) + (65536 - wu) * longint'(spec_mem[rl][f]) + 32768;
    res = acc >>> 16;   // floor
    if (res > SMAX) res = SMAX;
    if (res < SMIN) res = SMIN;
    return res[23:0];
  endfunction

  // Offers one transaction and waits for the handshake; bookkeeping happens
  // at acceptance so the shadow store follows the block's order exactly.
  task automatic send_item(input stim_t it);
    item_if.valid   <= 1'b1;
    item_if.opcode  <= it.op;
    item_if.k_index <= it.k;
    item_if.f_index <= it.f;
    item_if.v_index <= it.v;
    item_if.sample  <= it.s;
    do @(posedge clk_i); while (!item_if.ready);
    if (it.op == OP_WRITE) begin
      spec_mem[it.k][it.f]     = int'(it.s);
      spec_written[it.k][it.f] = 1'b1;
      n_writes++;
    end else begin
      value_q.push_back(it.has_exp ? it.exp_val : interp_value(it.f, it.v));
      n_queries++;
    end
    // Random gap on the sending side
    if (!quiet && $urandom_range(0, 9) == 0) begin
      item_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  task automatic write_sample(input logic [7:0] k, input logic [7:0] f,
                              input logic signed [23:0] s);
    stim_t it;
    it = '{OP_WRITE, k, f, '0, s, 1'b0, '0};
    send_item(it);
  endtask

  // Query with random content; rows it will read are written first so no
  // never-written entry is ever read.
  task automatic random_query();
    stim_t it;
    int ru, rl, off;
    longint wu;
    logic [7:0]  f;
    logic [10:0] v;
    f = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(1, 4));
    if ($urandom_range(0, 1)) begin
      v = 11'($urandom);
    end else begin
      off = $urandom_range(1, 40);
      if ($urandom_range(0, 1)) off = -off;
      off = int'(v_half) + off;
      if (off < 0) off = 0;
      v = 11'(off);
    end
    if (locate_rows(f, v, ru, rl, wu)) begin
      if (!spec_written[ru][f]) write_sample(8'(ru), f, 24'($urandom));
      if (!spec_written[rl][f]) write_sample(8'(rl), f, 24'($urandom));
    end
    it = '{OP_QUERY, 8'($urandom), f, v, 24'($urandom), 1'b0, '0};
    send_item(it);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [31:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_K_COUNT:       k_cnt  = data[KCNT_W-1:0];
      CFG_K_CENTER:      k_ctr  = data[KCTR_W-1:0];
      CFG_SLOPE_RATIO:   slope  = data[SLOPE_W-1:0];
      CFG_VELOCITY_HALF: v_half = data[VHALF_W-1:0];
      default: ;
    endcase
  endtask

  // Block must be idle before a register write: all results back, and the
  // trailing writes (which return nothing) flushed through the pipeline.
  task automatic drain();
    item_if.valid <= 1'b0;
    while (value_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY_WAIT) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [31:0] cnt, input logic [31:0] ctr,
                              input logic [31:0] slp, input logic [31:0] vh);
    cfg_write(CFG_K_COUNT, cnt);
    cfg_write(CFG_K_CENTER, ctr);
    cfg_write(CFG_SLOPE_RATIO, slp);
    cfg_write(CFG_VELOCITY_HALF, vh);
    n_phases++;
  endtask

  // Result side: random stalls, one long hold-off on request, in-order check
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (value_q.size() == 0) begin
          $error("value: expected none, actual %0d", res_if.value);
          errors++;
        end else begin
          logic signed [23:0] want;
          want = value_q.pop_front();
          if (res_if.value !== want) begin
            $error("value: expected %0d, actual %0d", want, res_if.value);
            errors++;
          end
          if (want != 0) n_nonzero++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = LONG_HOLD - 1;
        res_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    stim_t directed [$];
    int    phase_end;
    item_if.valid   <= 1'b0;
    item_if.opcode  <= OP_WRITE;
    item_if.k_index <= '0;
    item_if.f_index <= '0;
    item_if.v_index <= '0;
    item_if.sample  <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= CFG_K_COUNT;
    cfg_if.data     <= '0;
    k_cnt  = K_COUNT_RST;
    k_ctr  = K_CENTER_RST;
    slope  = SLOPE_RATIO_RST;
    v_half = VELOCITY_HALF_RST;

    // Directed pass, register defaults (center row 128, slope 1.0, half 100).
    // Expected values typed in where they are obvious.
    directed = '{
      '{OP_WRITE, 8'd0,   8'd0,   11'd0,    24'sd0,        1'b0, 24'sd0},
      '{OP_WRITE, 8'd255, 8'd255, 11'd2047, -24'sd1,       1'b0, 24'sd0},
      '{OP_WRITE, 8'd126, 8'd1,   11'd0,    -24'sd8388608, 1'b0, 24'sd0},
      '{OP_WRITE, 8'd127, 8'd1,   11'd0,    24'sd1000,     1'b0, 24'sd0},
      '{OP_WRITE, 8'd128, 8'd1,   11'd0,    -24'sd8388608, 1'b0, 24'sd0},
      '{OP_WRITE, 8'd129, 8'd1,   11'd0,    24'sd8388607,  1'b0, 24'sd0},
      '{OP_WRITE, 8'd130, 8'd1,   11'd0,    -24'sd5,       1'b0, 24'sd0},
      // zero frequency, zero velocity, outside the cone
      '{OP_QUERY, 8'd0,   8'd0,   11'd101,  24'sd0,        1'b1, 24'sd0},
      '{OP_QUERY, 8'd0,   8'd1,   11'd100,  24'sd0,        1'b1, 24'sd0},
      '{OP_QUERY, 8'd0,   8'd255, 11'd101,  24'sd0,        1'b1, 24'sd0},
      // exact row hits, positive and mirrored negative velocity, extremes
      '{OP_QUERY, 8'd0,   8'd1,   11'd101,  24'sd0,        1'b1, 24'sd8388607},
      '{OP_QUERY, 8'd0,   8'd1,   11'd99,   24'sd0,        1'b1, -24'sd8388608},
      // half-way and fractional weights
      '{OP_QUERY, 8'd0,   8'd1,   11'd102,  24'sd0,        1'b0, 24'sd0},
      '{OP_QUERY, 8'd0,   8'd1,   11'd98,   24'sd0,        1'b0, 24'sd0},
      '{OP_QUERY, 8'd255, 8'd1,   11'd2047, -24'sd1,       1'b0, 24'sd0},
      '{OP_QUERY, 8'd0,   8'd1,   11'd0,    24'sd0,        1'b0, 24'sd0}
    };

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_item(directed[i]);
    drain();

    // Register settings, extremes first; count below 2 and above the depth
    // are clamped, zero slope with zero center puts the position at row 0,
    // a center past the last row saturates the position.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: program_regs(2, 0, 0, 0);
        1: program_regs(511, 16777216, 32'hFFFF_FFFF, 1023);
        2: program_regs(1, 65536, 1, 1);
        3: program_regs(300, 3000000, 200000, 512);
        4: program_regs(64, 2097152, 12345678, 37);
        default: program_regs($urandom_range(2, 256), $urandom_range(0, 16777216),
                              $urandom_range(1, 4000000), $urandom_range(1, 1023));
      endcase
      if (ph == 1) hold_req = 1'b1;
      if (ph == 5) quiet = 1'b1;
      phase_end = n_writes + n_queries + PHASE_ITEMS;
      while (n_writes + n_queries < phase_end) begin
        if ($urandom_range(0, 9) < 3) begin
          // plain write, usually into the columns that queries favor
          write_sample(8'($urandom),
                       ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(1, 4)),
                       24'($urandom));
        end else begin
          random_query();
        end
      end
      drain();
    end

    $display("Covered %0d sample writes and %0d queries (%0d nonzero) over %0d settings.",
             n_writes, n_queries, n_nonzero, n_phases + 1);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/fkfv_pkg.sv
rtl/core/fkfv_intf.sv
rtl/core/fkfv_ram.sv
rtl/core/fkfv_div.sv
rtl/core/fk_to_fv_spectrum_resampler.sv
dv/tb_fk_to_fv_spectrum_resampler.sv
